>>> rtl/core/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants of the double-ended queue
// Word layouts of both channels, request and status codes and the cell control word.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Number of cells in the chain.
  localparam int Depth = 16;
  localparam int CntW  = $clog2(Depth + 1);
  localparam int IdxW  = $clog2(Depth);

  typedef logic [CntW-1:0]   cnt_t;
  typedef logic signed [31:0] value_t;

  // Request codes carried in the func field.
  localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
  localparam logic [2:0] FUNC_LIST_FWD   = 3'd4;
  localparam logic [2:0] FUNC_LIST_BWD   = 3'd5;

  // Status codes of a result word.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0] func;
    value_t     push_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    value_t     item_value;
    logic       last;
    logic [4:0] occupancy;
  } out_word_t;

  // Command broadcast to every cell in a cycle.
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_POP_FRONT,
    CMD_ROT_FWD,
    CMD_ROT_BWD
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    cnt_t count;
  } dq_ctrl_t;

endpackage

>>> rtl/core/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit values
// A chain of cells with the front element in the first cell.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the in channel (in_valid_i / in_ready_o with
// in_word_i), results leave on the out channel (out_valid_o / out_ready_i
// with out_word_o). Every result word is held in an output register until
// the receiver takes it; the next request is accepted in the same cycle the
// held word is taken.
// Pushes, pops and unused codes give one word each in the cycle after
// acceptance, so one request per cycle is sustained while words are taken.
// A pop back reads the back cell through a selector over the chain.
// A listing of n elements gives no word on acceptance, then one word per
// cycle while words are taken; the chain rotates one cell per step and is
// back in place after n steps. No request is accepted while a listing runs.
// When the receiver stalls, the output word holds and nothing moves.
// Reset empties the deque and clears the output register; cell contents are
// not cleared and are only read once a push has written them.
// ----------------------------------------------------------------------------
module double_ended_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dq_pkg::in_word_t    in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dq_pkg::out_word_t   out_word_o
);

  typedef enum logic {
    ST_RUN,
    ST_LIST
  } state_e;

  state_e            state_q, state_d;
  logic              out_valid_q, out_valid_d;
  dq_pkg::out_word_t out_q, out_d;
  dq_pkg::cnt_t      count_q, count_d;
  dq_pkg::cnt_t      remain_q, remain_d;
  logic              dir_bwd_q, dir_bwd_d;

  dq_pkg::dq_ctrl_t  ctrl;
  dq_pkg::value_t    cell_val [dq_pkg::Depth];
  dq_pkg::value_t    front_val;
  dq_pkg::value_t    back_val;
  logic              out_free;
  logic              accept;
  logic              full;
  logic              empty;

  // The cell chain.
  for (genvar g = 0; g < dq_pkg::Depth; g++) begin : g_cell
    dq_pkg::value_t left_val;
    dq_pkg::value_t right_val;
    if (g == 0) begin : g_first
      assign left_val = in_word_i.push_value;
    end else begin : g_mid_l
      assign left_val = cell_val[g-1];
    end
    if (g == dq_pkg::Depth - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[g+1];
    end
    dq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .cell_idx_i    (dq_pkg::CntW'(g)),
      .push_value_i  (in_word_i.push_value),
      .left_value_i  (left_val),
      .right_value_i (right_val),
      .front_value_i (front_val),
      .back_value_i  (back_val),
      .value_o       (cell_val[g])
    );
  end

  // Front and back element taps.
  assign front_val = cell_val[0];
  assign back_val  = cell_val[dq_pkg::IdxW'(count_q - dq_pkg::CntW'(1))];

  assign full     = (count_q == dq_pkg::CntW'(dq_pkg::Depth));
  assign empty    = (count_q == '0);
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_RUN) && out_free;
  assign accept   = in_valid_i && in_ready_o;

  // Request decode, listing sequencer and result word.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    count_d     = count_q;
    remain_d    = remain_q;
    dir_bwd_d   = dir_bwd_q;
    ctrl.cmd    = dq_pkg::CMD_HOLD;
    ctrl.count  = count_q;

    if (accept) begin
      out_valid_d         = 1'b1;
      out_d.status        = dq_pkg::STATUS_OK;
      out_d.item_value    = '0;
      out_d.last          = 1'b1;
      out_d.occupancy     = 5'(count_q);
      case (in_word_i.func)
        dq_pkg::FUNC_PUSH_FRONT, dq_pkg::FUNC_PUSH_BACK: begin
          if (full) begin
            out_d.status = dq_pkg::STATUS_FULL;
          end else begin
            ctrl.cmd = (in_word_i.func == dq_pkg::FUNC_PUSH_FRONT) ?
                       dq_pkg::CMD_PUSH_FRONT : dq_pkg::CMD_PUSH_BACK;
            count_d  = dq_pkg::CntW'(count_q + dq_pkg::CntW'(1));
            out_d.occupancy = 5'(count_d);
          end
        end
        dq_pkg::FUNC_POP_FRONT, dq_pkg::FUNC_POP_BACK: begin
          if (empty) begin
            out_d.status = dq_pkg::STATUS_EMPTY;
          end else begin
            if (in_word_i.func == dq_pkg::FUNC_POP_FRONT) begin
              ctrl.cmd         = dq_pkg::CMD_POP_FRONT;
              out_d.item_value = front_val;
            end else begin
              out_d.item_value = back_val;
            end
            count_d = dq_pkg::CntW'(count_q - dq_pkg::CntW'(1));
            out_d.occupancy = 5'(count_d);
          end
        end
        dq_pkg::FUNC_LIST_FWD, dq_pkg::FUNC_LIST_BWD: begin
          if (empty) begin
            out_d.status = dq_pkg::STATUS_EMPTY;
          end else begin
            out_valid_d = 1'b0;
            state_d     = ST_LIST;
            remain_d    = count_q;
            dir_bwd_d   = (in_word_i.func == dq_pkg::FUNC_LIST_BWD);
          end
        end
        default: begin
          out_d.status = dq_pkg::STATUS_OK;
        end
      endcase
    end else if (state_q == ST_LIST && out_free) begin
      // One listed element per cycle, while the receiver takes them, as the chain rotates.
      out_valid_d      = 1'b1;
      out_d.status     = dq_pkg::STATUS_OK;
      out_d.item_value = dir_bwd_q ? back_val : front_val;
      out_d.last       = (remain_q == dq_pkg::CntW'(1));
      out_d.occupancy  = 5'(count_q);
      ctrl.cmd         = dir_bwd_q ? dq_pkg::CMD_ROT_BWD : dq_pkg::CMD_ROT_FWD;
      remain_d         = dq_pkg::CntW'(remain_q - dq_pkg::CntW'(1));
      if (remain_q == dq_pkg::CntW'(1)) state_d = ST_RUN;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      remain_q    <= '0;
      dir_bwd_q   <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      dir_bwd_q   <= dir_bwd_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // The element count never exceeds the chain length.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= dq_pkg::CntW'(dq_pkg::Depth))
    else $error("element count above depth");

  // A running listing has elements left and never more than stored.
  a_list_remain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LIST |-> (remain_q != '0 && remain_q <= count_q))
    else $error("listing counter out of range");

  // A listing leaves the count untouched.
  a_list_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LIST |=> count_q == $past(count_q))
    else $error("count changed during listing");

  // An accepted push into a deque with room grows it by one.
  a_push_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !full && (in_word_i.func == dq_pkg::FUNC_PUSH_FRONT ||
                         in_word_i.func == dq_pkg::FUNC_PUSH_BACK))
    |=> count_q == dq_pkg::CntW'($past(count_q) + dq_pkg::CntW'(1)))
    else $error("push did not grow the deque");

  // A refused push is only reported on a full deque.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == dq_pkg::STATUS_FULL) |->
    out_q.occupancy == 5'(dq_pkg::Depth))
    else $error("full status with room left");

endmodule

>>> rtl/core/dq_cell.sv
// ----------------------------------------------------------------------------
// dq_cell: one storage cell of the deque chain
// Holds one value and takes its neighbor's, the pushed or a wrapped value
// according to the broadcast command and its own place in the chain.
// ----------------------------------------------------------------------------
module dq_cell (
  input  logic              clk_i,
  input  dq_pkg::dq_ctrl_t  ctrl_i,
  input  dq_pkg::cnt_t      cell_idx_i,
  input  dq_pkg::value_t    push_value_i,
  input  dq_pkg::value_t    left_value_i,
  input  dq_pkg::value_t    right_value_i,
  input  dq_pkg::value_t    front_value_i,
  input  dq_pkg::value_t    back_value_i,
  output dq_pkg::value_t    value_o
);

  dq_pkg::value_t value_q;
  dq_pkg::value_t value_d;
  dq_pkg::cnt_t   tail_idx;

  // Place of the back element in the chain.
  assign tail_idx = dq_pkg::CntW'(ctrl_i.count - dq_pkg::CntW'(1));

  // Pick the value this cell holds next.
  always_comb begin
    value_d = value_q;
    case (ctrl_i.cmd)
      dq_pkg::CMD_PUSH_FRONT: value_d = left_value_i;
      dq_pkg::CMD_PUSH_BACK: begin
        if (cell_idx_i == ctrl_i.count) value_d = push_value_i;
      end
      dq_pkg::CMD_POP_FRONT: value_d = right_value_i;
      dq_pkg::CMD_ROT_FWD: begin
        if (cell_idx_i == tail_idx) value_d = front_value_i;
        else                        value_d = right_value_i;
      end
      dq_pkg::CMD_ROT_BWD: begin
        if (cell_idx_i == '0) value_d = back_value_i;
        else                  value_d = left_value_i;
      end
      default: value_d = value_q;
    endcase
  end

  // Payload register, no reset.
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule
